### sv/dzts_pkg.sv
// Shared types, widths and constants for the dead-zone location search.
`timescale 1ns / 1ps
`default_nettype none

package dzts_pkg;

   // Point store depth
   localparam int MAX_POINTS = 4096;
   localparam int ADDR_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);

   // Field widths
   localparam int POS_W    = 30;
   localparam int WEIGHT_W = 16;
   localparam int RADIUS_W = 30;
   localparam int COST_W   = 63;

   // Probe position reaches lo+1, one bit above a position
   localparam int X_W    = POS_W + 1;
   localparam int PROD_W = WEIGHT_W + X_W;
   localparam int SUM_W  = PROD_W + CNT_W;

   // floor(d/3) = (d * DIV3_MUL) >> DIV3_SHIFT, exact for d below 2^32
   localparam logic [31:0] DIV3_MUL   = 32'hAAAA_AAAB;
   localparam int          DIV3_SHIFT = 33;
   localparam int          DIV3_W     = POS_W + 32;

   // One stored point
   typedef struct packed {
      logic [RADIUS_W-1:0] radius;
      logic [WEIGHT_W-1:0] weight;
      logic [POS_W-1:0]    position;
   } point_type;

   localparam int POINT_W = $bits(point_type);

   // Sequencer to cost unit
   typedef struct packed {
      logic             start;
      logic [X_W-1:0]   x;
      logic [CNT_W-1:0] count;
   } cost_ctl_type;

   // Cost unit to sequencer
   typedef struct packed {
      logic             done;
      logic [SUM_W-1:0] sum;
   } cost_rsp_type;

endpackage

`default_nettype wire

### sv/dzts_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module dzts_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### sv/dzts_cost.sv
// Shared cost unit: streams the stored points through a weighted-excess MAC.
`timescale 1ns / 1ps
`default_nettype none

module dzts_cost (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire dzts_pkg::cost_ctl_type          ctl,
   output dzts_pkg::cost_rsp_type               rsp,
   output logic                                 rd_en,
   output logic [dzts_pkg::ADDR_W-1:0]          rd_addr,
   input  wire dzts_pkg::point_type             rd_point
);

   // Control
   logic                        running_ff, running_in;
   logic [dzts_pkg::CNT_W-1:0]  idx_ff, idx_in;
   logic [dzts_pkg::CNT_W-1:0]  count_ff;
   logic [dzts_pkg::X_W-1:0]    x_ff;
   logic                        v1_ff, v2_ff, v3_ff, v4_ff;
   logic                        done_ff, done_in;

   // Datapath
   logic [dzts_pkg::X_W-1:0]      dist1_ff;
   logic [dzts_pkg::RADIUS_W-1:0] rad1_ff;
   logic [dzts_pkg::WEIGHT_W-1:0] wt1_ff, wt2_ff;
   logic [dzts_pkg::X_W-1:0]      exc2_ff;
   logic [dzts_pkg::PROD_W-1:0]   prod3_ff;
   logic [dzts_pkg::SUM_W-1:0]    acc_ff;

   logic [dzts_pkg::X_W-1:0] pos_x;
   logic [dzts_pkg::X_W-1:0] rad_x;
   logic                     issue;
   logic                     finish;

   assign pos_x = dzts_pkg::X_W'(rd_point.position);
   assign rad_x = dzts_pkg::X_W'(rad1_ff);

   // Issue one point read per cycle until all are out
   assign issue   = running_ff && (idx_ff < count_ff);
   assign rd_en   = issue;
   assign rd_addr = idx_ff[dzts_pkg::ADDR_W-1:0];

   // Done once everything is issued and the pipe has drained
   assign finish = running_ff && !issue && !v1_ff && !v2_ff && !v3_ff && !v4_ff;

   always_comb begin
      running_in = running_ff;
      idx_in     = idx_ff;
      done_in    = 1'b0;
      if (ctl.start) begin
         running_in = 1'b1;
         idx_in     = '0;
      end else if (issue) begin
         idx_in = idx_ff + 1'b1;
      end else if (finish) begin
         running_in = 1'b0;
         done_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         idx_ff     <= '0;
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         v3_ff      <= 1'b0;
         v4_ff      <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         running_ff <= running_in;
         idx_ff     <= idx_in;
         v1_ff      <= issue;
         v2_ff      <= v1_ff;
         v3_ff      <= v2_ff;
         v4_ff      <= v3_ff;
         done_ff    <= done_in;
      end
   end

   // Stage 1: distance to the probe; stage 2: excess past radius;
   // stage 3: weight product; stage 4: accumulate
   always_ff @(posedge clock) begin
      if (ctl.start) begin
         x_ff     <= ctl.x;
         count_ff <= ctl.count;
         acc_ff   <= '0;
      end else if (v4_ff) begin
         acc_ff <= acc_ff + dzts_pkg::SUM_W'(prod3_ff);
      end

      dist1_ff <= (x_ff >= pos_x) ? (x_ff - pos_x) : (pos_x - x_ff);
      rad1_ff  <= rd_point.radius;
      wt1_ff   <= rd_point.weight;

      exc2_ff <= (dist1_ff > rad_x) ? (dist1_ff - rad_x) : '0;
      wt2_ff  <= wt1_ff;

      prod3_ff <= dzts_pkg::PROD_W'(wt2_ff * exc2_ff);
   end

   assign rsp.done = done_ff;
   assign rsp.sum  = acc_ff;

endmodule

`default_nettype wire

### sv/deadzone_location_ternary_search.sv
// Top level: point loading, ternary search sequencer and result register.
// Loading: one point per cycle, busy stays low until an item with last set.
// Each cost evaluation streams all N stored points through the shared MAC.
// A step runs S_DIFF to S_MID1 and two evaluations; steps until hi - lo <= 2,
// then three more evaluations. The result strobe is one cycle; no stall possible.
// Reset clears the point count and bounds; point storage is undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module deadzone_location_ternary_search (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [dzts_pkg::POS_W-1:0]      req_position,
   input  wire logic [dzts_pkg::WEIGHT_W-1:0]   req_weight,
   input  wire logic [dzts_pkg::RADIUS_W-1:0]   req_radius,
   input  wire logic                            req_last,
   output logic                                 rsp_valid,
   output logic [dzts_pkg::COST_W-1:0]          rsp_min_cost
);

   // Sequencer states
   localparam logic [3:0] S_LOAD   = 4'd0;
   localparam logic [3:0] S_DIFF   = 4'd1;
   localparam logic [3:0] S_DIV    = 4'd2;
   localparam logic [3:0] S_THIRD  = 4'd3;
   localparam logic [3:0] S_MID1   = 4'd4;
   localparam logic [3:0] S_F1     = 4'd5;
   localparam logic [3:0] S_F2     = 4'd6;
   localparam logic [3:0] S_F_LO   = 4'd7;
   localparam logic [3:0] S_F_LO1  = 4'd8;
   localparam logic [3:0] S_F_HI   = 4'd9;

   localparam logic [dzts_pkg::CNT_W-1:0] FULL = dzts_pkg::CNT_W'(dzts_pkg::MAX_POINTS);

   logic [3:0]                    state_ff, state_in;
   logic [dzts_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [dzts_pkg::POS_W-1:0]    min_ff, min_in;
   logic [dzts_pkg::POS_W-1:0]    max_ff, max_in;
   logic [dzts_pkg::POS_W-1:0]    lo_ff, lo_in;
   logic [dzts_pkg::POS_W-1:0]    hi_ff, hi_in;
   logic [dzts_pkg::POS_W-1:0]    diff_ff, diff_in;
   logic [dzts_pkg::DIV3_W-1:0]   prod_ff, prod_in;
   logic [dzts_pkg::POS_W-1:0]    m1_ff, m1_in;
   logic [dzts_pkg::POS_W-1:0]    m2_ff, m2_in;
   logic [dzts_pkg::SUM_W-1:0]    f1_ff, f1_in;
   logic [dzts_pkg::SUM_W-1:0]    best_ff, best_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [dzts_pkg::COST_W-1:0]   rsp_cost_ff, rsp_cost_in;

   logic                          accept;
   logic                          store;
   logic [dzts_pkg::POS_W-1:0]    third;
   dzts_pkg::cost_ctl_type        cost_ctl;
   dzts_pkg::cost_rsp_type        cost_rsp;
   dzts_pkg::point_type           wr_point;
   dzts_pkg::point_type           rd_point;
   logic                          rd_en;
   logic [dzts_pkg::ADDR_W-1:0]   rd_addr;

   assign busy   = (state_ff != S_LOAD);
   assign accept = start && !busy;
   assign store  = accept && (count_ff != FULL);
   assign third  = dzts_pkg::POS_W'(prod_ff >> dzts_pkg::DIV3_SHIFT);

   assign wr_point.position = req_position;
   assign wr_point.weight   = req_weight;
   assign wr_point.radius   = req_radius;

   // Point store
   dzts_ram #(
      .WIDTH  (dzts_pkg::POINT_W),
      .DEPTH  (dzts_pkg::MAX_POINTS),
      .ADDR_W (dzts_pkg::ADDR_W)
   ) u_points (
      .clock   (clock),
      .wr_en   (store),
      .wr_addr (count_ff[dzts_pkg::ADDR_W-1:0]),
      .wr_data (wr_point),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_point)
   );

   // Shared cost evaluator
   dzts_cost u_cost (
      .clock    (clock),
      .reset    (reset),
      .ctl      (cost_ctl),
      .rsp      (cost_rsp),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_point (rd_point)
   );

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      diff_in      = diff_ff;
      prod_in      = prod_ff;
      m1_in        = m1_ff;
      m2_in        = m2_ff;
      f1_in        = f1_ff;
      best_in      = best_ff;
      rsp_valid_in = 1'b0;
      rsp_cost_in  = rsp_cost_ff;
      cost_ctl.start = 1'b0;
      cost_ctl.x     = dzts_pkg::X_W'(lo_ff);
      cost_ctl.count = count_ff;

      case (state_ff)
         S_LOAD: begin
            if (store) begin
               count_in = count_ff + 1'b1;
               if (req_position < min_ff) begin
                  min_in = req_position;
               end
               if (req_position > max_ff) begin
                  max_in = req_position;
               end
            end
            if (accept && req_last) begin
               lo_in    = min_in;
               hi_in    = max_in;
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            diff_in  = hi_ff - lo_ff;
            state_in = S_DIV;
         end
         S_DIV: begin
            // Narrow interval: finish with lo, lo+1 and hi
            if (diff_ff > dzts_pkg::POS_W'(2)) begin
               prod_in  = dzts_pkg::DIV3_W'(diff_ff * dzts_pkg::DIV3_MUL);
               state_in = S_THIRD;
            end else begin
               cost_ctl.start = 1'b1;
               cost_ctl.x     = dzts_pkg::X_W'(lo_ff);
               state_in       = S_F_LO;
            end
         end
         S_THIRD: begin
            m1_in    = lo_ff + third;
            m2_in    = hi_ff - third;
            state_in = S_MID1;
         end
         S_MID1: begin
            cost_ctl.start = 1'b1;
            cost_ctl.x     = dzts_pkg::X_W'(m1_ff);
            state_in       = S_F1;
         end
         S_F1: begin
            if (cost_rsp.done) begin
               f1_in          = cost_rsp.sum;
               cost_ctl.start = 1'b1;
               cost_ctl.x     = dzts_pkg::X_W'(m2_ff);
               state_in       = S_F2;
            end
         end
         S_F2: begin
            // Equal thirds move both ends
            if (cost_rsp.done) begin
               if (f1_ff >= cost_rsp.sum) begin
                  lo_in = m1_ff;
               end
               if (f1_ff <= cost_rsp.sum) begin
                  hi_in = m2_ff;
               end
               state_in = S_DIFF;
            end
         end
         S_F_LO: begin
            if (cost_rsp.done) begin
               best_in        = cost_rsp.sum;
               cost_ctl.start = 1'b1;
               cost_ctl.x     = dzts_pkg::X_W'(lo_ff) + 1'b1;
               state_in       = S_F_LO1;
            end
         end
         S_F_LO1: begin
            if (cost_rsp.done) begin
               if (cost_rsp.sum < best_ff) begin
                  best_in = cost_rsp.sum;
               end
               cost_ctl.start = 1'b1;
               cost_ctl.x     = dzts_pkg::X_W'(hi_ff);
               state_in       = S_F_HI;
            end
         end
         S_F_HI: begin
            // Deliver and start a new set
            if (cost_rsp.done) begin
               rsp_valid_in = 1'b1;
               rsp_cost_in  = (cost_rsp.sum < best_ff) ?
                              dzts_pkg::COST_W'(cost_rsp.sum) :
                              dzts_pkg::COST_W'(best_ff);
               count_in     = '0;
               min_in       = '1;
               max_in       = '0;
               state_in     = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         min_ff       <= '1;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Search payload registers
   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      diff_ff     <= diff_in;
      prod_ff     <= prod_in;
      m1_ff       <= m1_in;
      m2_ff       <= m2_in;
      f1_ff       <= f1_in;
      best_ff     <= best_in;
      rsp_cost_ff <= rsp_cost_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_min_cost = rsp_cost_ff;

endmodule

`default_nettype wire
